/* rtl/core/fbpa_pkg.sv */
// Shared types, codes and defaults for the fixed block pool allocator.
`timescale 1ns / 1ps
package fbpa_pkg;
   localparam int MaxBlocksDefault = 256;
   localparam int AddrBitsDefault  = 32;
   localparam int PtrBytesDefault  = 4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_BUSY    = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BYTES = 2'd1;
   localparam logic [1:0] CSR_BLOCK_TOTAL = 2'd2;

   // One queued command between the front and the back.
   typedef struct packed {
      logic        opcode;
      logic [31:0] block_address;
   } cmd_type;

   // One finished result.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
      logic [8:0]  free_blocks;
      logic [8:0]  peak_in_use;
      logic [31:0] alloc_total;
   } rsp_type;
endpackage

/* rtl/core/fbpa_front.sv */
// Front end: accepts commands into a two-entry queue.
`timescale 1ns / 1ps
module fbpa_front
   import fbpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= in_cmd;
   end
endmodule

/* rtl/core/fbpa_divider.sv */
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module fbpa_divider #(
   parameter int NumBits = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NumBits-1:0] dividend,
   input  logic [NumBits-1:0] divisor,
   output logic               done,
   output logic [NumBits-1:0] quotient,
   output logic [NumBits-1:0] remainder
);
   localparam int CntBits = $clog2(NumBits + 1);
   logic [NumBits-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [NumBits:0]   trial;

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[NumBits-1]} - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CntBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NumBits]) begin
            rem_in = trial[NumBits-1:0];
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NumBits-2:0], quo_ff[NumBits-1]};
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
   end
endmodule

/* rtl/core/fbpa_back.sv */
// Back end: pool state, free stack and command execution.
`timescale 1ns / 1ps
module fbpa_back
   import fbpa_pkg::*;
#(
   parameter int MaxBlocks = MaxBlocksDefault,
   parameter int AddrBits  = AddrBitsDefault,
   parameter int PtrBytes  = PtrBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);
   localparam int IdxBits = $clog2(MaxBlocks);
   localparam int CntBits = $clog2(MaxBlocks + 1);
   localparam int DivBits = 33;
   localparam int PtrLog  = $clog2(PtrBytes);
   // Granted addresses wrap at the address width before they are cut to 32 bits.
   localparam logic [31:0] GrantMask = (AddrBits >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << AddrBits) - 64'd1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_ALLOC = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [31:0]        base_ff;
   logic [15:0]        bytes_ff;
   logic [8:0]         total_ff;
   logic [17:0]        size_ff;
   logic [26:0]        pool_ff;
   logic               ok_ff;
   logic [CntBits-1:0] depth_ff, fresh_ff, freec_ff, peak_ff;
   logic [31:0]        allocs_ff;
   logic [MaxBlocks-1:0] map_ff;
   logic [IdxBits-1:0] stack_mem [MaxBlocks];
   logic [IdxBits-1:0] rd_data_ff;
   cmd_type            cmd_ff;
   rsp_type            rsp_ff;
   logic               rsp_v_ff;
   logic [1:0]         stat_ff;
   logic [31:0]        grant_ff;
   logic [32:0]        off_ff;
   logic               div_start, div_done;
   logic [DivBits-1:0] div_q, div_r;
   logic [17:0]        size_new;
   logic [26:0]        pool_new;
   logic [IdxBits-1:0] grant_idx;
   logic [CntBits-1:0] used;
   logic [33:0]        grant_sum;
   logic [8:0]         total_w;
   logic [15:0]        bytes_w;
   logic               restart;

   assign cmd_ready = (state_ff == S_IDLE) && !restart;
   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;
   assign div_start = (state_ff == S_READ) && (cmd_ff.opcode == OP_FREE);
   assign restart   = csr_write && (csr_index == CSR_POOL_BASE
                      || csr_index == CSR_BLOCK_BYTES || csr_index == CSR_BLOCK_TOTAL);

   always_comb begin
      bytes_w  = (csr_write && csr_index == CSR_BLOCK_BYTES) ? csr_data[15:0] : bytes_ff;
      total_w  = (csr_write && csr_index == CSR_BLOCK_TOTAL) ? csr_data[8:0] : total_ff;
      size_new = ({2'b0, bytes_w} + 18'(PtrBytes - 1)) >> PtrLog << PtrLog;
      if (size_new < 18'(PtrBytes)) size_new = 18'(PtrBytes);
      pool_new = 27'(size_new) * 27'(total_w);
   end

   fbpa_divider #(.NumBits(DivBits)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(off_ff), .divisor(33'(size_ff)), .done(div_done),
      .quotient(div_q), .remainder(div_r)
   );

   assign grant_idx = (depth_ff != '0) ? rd_data_ff : fresh_ff[IdxBits-1:0];
   assign used      = CntBits'(total_ff) - (freec_ff - 1'b1);
   assign grant_sum = 34'(base_ff) + 34'(grant_idx) * 34'(size_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (cmd_valid && !restart) state_in = S_READ;
         S_READ:  state_in = (cmd_ff.opcode == OP_ALLOC) ? S_ALLOC : S_DIV;
         S_ALLOC: state_in = S_OUT;
         S_DIV:   if (div_done) state_in = S_CHECK;
         S_CHECK: state_in = S_OUT;
         S_OUT:   if (!rsp_v_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem[IdxBits'(depth_ff - 1'b1)];
      if (state_ff == S_CHECK && ok_ff && cmd_ff.block_address != 32'd0
          && !off_ff[32] && off_ff[26:0] < pool_ff && off_ff[32:27] == 6'd0
          && div_r == '0 && freec_ff < CntBits'(total_ff)
          && div_q < DivBits'(fresh_ff) && !map_ff[div_q[IdxBits-1:0]])
         stack_mem[depth_ff[IdxBits-1:0]] <= div_q[IdxBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; base_ff <= '0; bytes_ff <= '0; total_ff <= '0;
         size_ff <= 18'(PtrBytes); pool_ff <= '0; ok_ff <= 1'b0;
         depth_ff <= '0; fresh_ff <= '0; freec_ff <= '0; peak_ff <= '0;
         allocs_ff <= '0; map_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (restart) begin
            if (csr_index == CSR_POOL_BASE) base_ff <= csr_data;
            bytes_ff <= bytes_w;
            total_ff <= total_w;
            size_ff  <= size_new;
            pool_ff  <= pool_new;
            ok_ff    <= bytes_w != 16'd0 && total_w != 9'd0 && 32'(total_w) <= 32'(MaxBlocks)
                        && 64'(pool_new) - 64'd1 <= ((64'd1 << (AddrBits-1)) << 1) - 64'd1;
            freec_ff <= (bytes_w != 16'd0 && total_w != 9'd0 && 32'(total_w) <= 32'(MaxBlocks)
                         && 64'(pool_new) - 64'd1 <= ((64'd1 << (AddrBits-1)) << 1) - 64'd1)
                        ? CntBits'(total_w) : '0;
            depth_ff <= '0; fresh_ff <= '0; peak_ff <= '0; allocs_ff <= '0; map_ff <= '0;
         end else begin
            if (state_ff == S_IDLE && cmd_valid) begin
               cmd_ff <= cmd;
               off_ff <= {1'b0, cmd.block_address} - {1'b0, base_ff};
            end
            // Status and address wait here so a held result stays intact.
            if (state_ff == S_ALLOC) begin
               if (!ok_ff || freec_ff == '0
                   || (depth_ff == '0 && fresh_ff >= CntBits'(total_ff))) begin
                  stat_ff  <= ST_EMPTY;
                  grant_ff <= '0;
               end else begin
                  stat_ff  <= ST_OK;
                  grant_ff <= grant_sum[31:0] & GrantMask;
                  if (depth_ff != '0) begin
                     depth_ff <= depth_ff - 1'b1;
                     map_ff[rd_data_ff] <= 1'b0;
                  end else fresh_ff <= fresh_ff + 1'b1;
                  freec_ff  <= freec_ff - 1'b1;
                  allocs_ff <= allocs_ff + 32'd1;
                  if (used > peak_ff) peak_ff <= used;
               end
            end
            if (state_ff == S_CHECK) begin
               grant_ff <= '0;
               if (!ok_ff || cmd_ff.block_address == 32'd0 || off_ff[32]
                   || off_ff[32:27] != 6'd0 || off_ff[26:0] >= pool_ff || div_r != '0)
                  stat_ff <= ST_INVALID;
               else if (freec_ff >= CntBits'(total_ff) || div_q >= DivBits'(fresh_ff)
                        || map_ff[div_q[IdxBits-1:0]])
                  stat_ff <= ST_BUSY;
               else begin
                  stat_ff  <= ST_OK;
                  depth_ff <= depth_ff + 1'b1;
                  map_ff[div_q[IdxBits-1:0]] <= 1'b1;
                  freec_ff <= freec_ff + 1'b1;
               end
            end
         end
         if (state_ff == S_OUT && (!rsp_v_ff || rsp_ready)) begin
            rsp_v_ff <= 1'b1;
            rsp_ff.status          <= stat_ff;
            rsp_ff.granted_address <= grant_ff;
            rsp_ff.free_blocks     <= 9'(freec_ff);
            rsp_ff.peak_in_use     <= 9'(peak_ff);
            rsp_ff.alloc_total     <= allocs_ff;
         end else if (rsp_v_ff && rsp_ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end
endmodule

/* rtl/core/fixed_block_pool_allocator.sv */
// Top level of the fixed-size block pool allocator.
`timescale 1ns / 1ps
// Channel   Direction  Content
// req_*     in         command transfer: opcode in tuser, block_address in tdata
// rsp_*     out        result transfer: status, address, counters
// csr_*     in         register write: pool_base, block_bytes, block_total
// An allocate steps through read, allocate and output; a free through read, divide,
// check and output, with the one-bit-per-cycle divider checking block alignment.
// Reset is synchronous and leaves the pool unconfigured (every op fails).
// A two-entry command queue keeps req_tready high while the back end works until both
// entries fill, and the result register holds a result until rsp_tready takes it.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = MaxBlocksDefault,
   parameter int ADDR_BITS  = AddrBitsDefault,
   parameter int PTR_BYTES  = PtrBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,  // opcode[0]
   input  logic [31:0] req_tdata,  // block_address[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // status[1:0], granted_address[33:2],
                                   // free_blocks[42:34], peak_in_use[51:43],
                                   // alloc_total[83:52], zero fill
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   cmd_type in_cmd, q_cmd;
   rsp_type rsp;
   logic    q_valid, q_ready;

   assign in_cmd.opcode        = req_tuser;
   assign in_cmd.block_address = req_tdata;

   // The front queue decouples command intake from execution.
   fbpa_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   // The back end owns all pool state and produces one result per command.
   fbpa_back #(.MaxBlocks(MAX_BLOCKS), .AddrBits(ADDR_BITS), .PtrBytes(PTR_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp)
   );

   assign rsp_tdata = {4'd0, rsp.alloc_total, rsp.peak_in_use, rsp.free_blocks,
                       rsp.granted_address, rsp.status};

   // A failed result never carries a granted address.
   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status != ST_OK |-> rsp.granted_address == 32'd0)
      else $error("granted address on failed result");

   // A held result keeps its payload while the consumer stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
endmodule

/* sim/fixed_block_pool_allocator_test.sv */
// Self-checking testbench for the fixed block pool allocator.
`timescale 1ns / 1ps
module fixed_block_pool_allocator_test;
   import fbpa_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_POOL_BASE;
   logic [31:0] csr_data = '0;

   fixed_block_pool_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the pool registers and bookkeeping.
   logic [31:0] base_reg;
   logic [15:0] bytes_reg;
   logic [8:0]  total_reg;
   logic [63:0] slot_size;
   bit          pool_valid;
   logic [7:0]  lifo [256];
   int          lifo_depth;
   int          fresh_next;
   bit          on_lifo [256];
   int          blocks_free;
   int          peak_count;
   logic [31:0] grant_count;

   rsp_type     pending_rsp [$];
   logic [31:0] granted_list [$];   // granted addresses, for frees (a freed one may stay)
   int          failures = 0;
   bit          quiet = 1'b0;       // a long stretch with no idling

   // Recompute derived values and restart the pool after any register write.
   function automatic void restart_pool();
      logic [63:0] sz;
      sz = (bytes_reg < 4) ? 64'd4 : 64'(bytes_reg);
      sz = (sz + 3) / 4 * 4;
      slot_size  = sz;
      pool_valid = bytes_reg != 0 && total_reg != 0 && total_reg <= 256
                   && (sz * total_reg - 1) <= 64'hFFFF_FFFF;
      for (int i = 0; i < 256; i++) on_lifo[i] = 1'b0;
      lifo_depth  = 0;
      fresh_next  = 0;
      blocks_free = pool_valid ? int'(total_reg) : 0;
      peak_count  = 0;
      grant_count = '0;
      granted_list.delete();
   endfunction

   // Work out the result of one command and advance the shadow state.
   function automatic rsp_type predict_pool_op(logic op, logic [31:0] addr);
      rsp_type r;
      int          idx;
      logic [63:0] off;
      r = '0;
      if (op == OP_ALLOC) begin
         r.status = ST_EMPTY;
         if (pool_valid && blocks_free != 0) begin
            idx = -1;
            if (lifo_depth > 0) begin
               lifo_depth--;
               idx = lifo[lifo_depth];
               on_lifo[idx] = 1'b0;
            end else if (fresh_next < total_reg) begin
               idx = fresh_next;
               fresh_next++;
            end
            if (idx >= 0) begin
               blocks_free--;
               grant_count++;
               if (int'(total_reg) - blocks_free > peak_count)
                  peak_count = int'(total_reg) - blocks_free;
               r.status = ST_OK;
               r.granted_address = 32'(64'(base_reg) + 64'(idx) * slot_size);
               granted_list.push_back(r.granted_address);
            end
         end
      end else begin
         r.status = ST_INVALID;
         off = 64'(addr) - 64'(base_reg);
         if (pool_valid && addr != 0 && addr >= base_reg
             && off < slot_size * total_reg && off % slot_size == 0) begin
            idx = int'(off / slot_size);
            if (blocks_free >= total_reg || idx >= fresh_next || on_lifo[idx]
                || lifo_depth >= 256) begin
               r.status = ST_BUSY;
            end else begin
               lifo[lifo_depth] = 8'(idx);
               lifo_depth++;
               on_lifo[idx] = 1'b1;
               blocks_free++;
               r.status = ST_OK;
            end
         end
      end
      r.free_blocks = 9'(blocks_free);
      r.peak_in_use = 9'(peak_count);
      r.alloc_total = grant_count;
      return r;
   endfunction

   // Write one register while the block is idle, then restart the shadow.
   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_POOL_BASE:   base_reg  = value;
         CSR_BLOCK_BYTES: bytes_reg = value[15:0];
         default:         total_reg = value[8:0];
      endcase
      restart_pool();
   endtask

   task automatic set_pool(logic [31:0] b, logic [15:0] sz, logic [8:0] n);
      write_reg(CSR_POOL_BASE, b);
      write_reg(CSR_BLOCK_BYTES, 32'(sz));
      write_reg(CSR_BLOCK_TOTAL, 32'(n));
   endtask

   // Send one command transfer; the expectation is queued at acceptance.
   // Valid stays high afterwards unless the next call idles first.
   task automatic send_cmd(logic op, logic [31:0] addr);
      while (!quiet && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_pool_op(op, addr));
   endtask

   // Wait until all results are in, plus room for a late free to settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Result side: random back-pressure and field-by-field compare.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status          = rsp_tdata[1:0];
         got.granted_address = rsp_tdata[33:2];
         got.free_blocks     = rsp_tdata[42:34];
         got.peak_in_use     = rsp_tdata[51:43];
         got.alloc_total     = rsp_tdata[83:52];
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               failures++;
            end
            if (got.granted_address !== want.granted_address) begin
               $error("granted_address expected %h actual %h",
                      want.granted_address, got.granted_address);
               failures++;
            end
            if (got.free_blocks !== want.free_blocks) begin
               $error("free_blocks expected %0d actual %0d",
                      want.free_blocks, got.free_blocks);
               failures++;
            end
            if (got.peak_in_use !== want.peak_in_use) begin
               $error("peak_in_use expected %0d actual %0d",
                      want.peak_in_use, got.peak_in_use);
               failures++;
            end
            if (got.alloc_total !== want.alloc_total) begin
               $error("alloc_total expected %0d actual %0d",
                      want.alloc_total, got.alloc_total);
               failures++;
            end
         end
      end
      rsp_tready <= quiet || ($urandom_range(99) >= 21);
   end

   // Directed rows: a config to apply (when set), then a command. The status
   // is typed in only where it is plain; other rows rely on the predictor.
   typedef struct {
      bit          do_cfg;
      logic [31:0] base;
      logic [15:0] bytes;
      logic [8:0]  total;
      logic        op;
      logic [31:0] addr;
      bit          known;
      logic [1:0]  status;
   } row_type;

   row_type directed [] = '{
      // Unconfigured after reset: allocate is empty, free is invalid.
      '{0, 0, 0, 0, OP_ALLOC, 0, 1, ST_EMPTY},
      '{0, 0, 0, 0, OP_FREE, 32'hFFFF_FFFF, 1, ST_INVALID},
      // Small pool, sizes rounded up to the pointer size.
      '{1, 32'h1000, 1, 2, OP_ALLOC, 0, 1, ST_OK},
      '{0, 0, 0, 0, OP_ALLOC, 0, 1, ST_OK},
      '{0, 0, 0, 0, OP_ALLOC, 0, 1, ST_EMPTY},
      '{0, 0, 0, 0, OP_FREE, 32'h1004, 1, ST_OK},
      '{0, 0, 0, 0, OP_FREE, 32'h1004, 1, ST_BUSY},      // double free
      '{0, 0, 0, 0, OP_FREE, 32'h1002, 1, ST_INVALID},   // misaligned
      '{0, 0, 0, 0, OP_FREE, 32'h0FFC, 1, ST_INVALID},   // below the pool
      '{0, 0, 0, 0, OP_FREE, 32'h1008, 1, ST_INVALID},   // past the end
      '{0, 0, 0, 0, OP_FREE, 0, 1, ST_INVALID},          // zero address
      '{0, 0, 0, 0, OP_ALLOC, 0, 1, ST_OK},
      // Pool at address zero: block zero can never be freed.
      '{1, 0, 16'd6, 3, OP_ALLOC, 0, 1, ST_OK},
      '{0, 0, 0, 0, OP_FREE, 0, 1, ST_INVALID},
      // Pool that wraps past the top of the address space.
      '{1, 32'hFFFF_FFF0, 16'hFFFF, 256, OP_ALLOC, 0, 0, 0},
      '{0, 0, 0, 0, OP_ALLOC, 0, 0, 0},
      '{0, 0, 0, 0, OP_FREE, 32'hFFFF_FFF0, 1, ST_OK},
      // A zero block count leaves the pool unconfigured; then a full-size
      // pool of 256 large blocks in the upper half of the address space.
      '{1, 0, 16'hFFFF, 0, OP_ALLOC, 0, 1, ST_EMPTY},
      '{1, 32'h8000_0000, 16'hFFFC, 256, OP_ALLOC, 0, 0, 0},
      '{0, 0, 0, 0, OP_FREE, 32'h8000_0000, 1, ST_OK},
      // Too many blocks is invalid.
      '{1, 32'h4000, 16'd8, 257, OP_ALLOC, 0, 1, ST_EMPTY},
      '{0, 0, 0, 0, OP_FREE, 32'h4000, 1, ST_INVALID}
   };

   initial begin
      rsp_type     want;
      logic [31:0] a;
      int          pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      base_reg = '0; bytes_reg = '0; total_reg = '0;
      restart_pool();

      foreach (directed[i]) begin
         if (directed[i].do_cfg) begin
            drain();
            set_pool(directed[i].base, directed[i].bytes, directed[i].total);
         end
         send_cmd(directed[i].op, directed[i].addr);
         want = pending_rsp[$];
         if (directed[i].known && want.status !== directed[i].status) begin
            $error("status expected %0d actual %0d (predictor)",
                   directed[i].status, want.status);
            failures++;
         end
      end

      // Random phases: fresh pool settings, then a mix mostly of valid
      // alloc/free sequences with some noise addresses.
      for (int phase = 0; phase < 12; phase++) begin
         drain();
         quiet = (phase == 5);
         case (phase % 4)
            0: set_pool($urandom, 16'($urandom_range(1, 64)), 9'($urandom_range(1, 8)));
            1: set_pool($urandom & 32'hFFFF_0000, 16'($urandom), 9'($urandom_range(1, 256)));
            2: set_pool(32'($urandom_range(1, 4096)), 16'($urandom_range(0, 3)),
                        9'($urandom_range(1, 16)));
            default: set_pool(32'hFFFF_FFFF - $urandom_range(0, 255),
                              16'($urandom_range(1, 12)), 9'($urandom_range(1, 40)));
         endcase
         for (int k = 0; k < 50; k++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               send_cmd(OP_ALLOC, $urandom);
            end else if (pick < 85 && granted_list.size() != 0) begin
               pick = $urandom_range(granted_list.size() - 1);
               a = granted_list[pick];
               if ($urandom_range(3) != 0) granted_list.delete(pick);
               send_cmd(OP_FREE, a);
            end else if (pick < 92) begin
               send_cmd(OP_FREE, base_reg + 32'($urandom_range(0, 64)));
            end else begin
               send_cmd(OP_FREE, $urandom);
            end
         end
      end
      quiet = 1'b0;
      drain();

      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
